### rtl/core/diff_drive_wheel_pi_controller_assert.svh
// Assertion macros used by the checker of the wheel PI controller.
`ifndef DIFF_DRIVE_WHEEL_PI_CONTROLLER_ASSERT_SVH
`define DIFF_DRIVE_WHEEL_PI_CONTROLLER_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define DDPI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define DDPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ddpi_pkg.sv
// Types, constants and microcode program of the wheel PI controller.
package ddpi_pkg;

  localparam int TURN_W = 17;
  localparam int VEL_W  = 18;
  localparam int MEAS_W = 25;
  localparam int TGT_W  = 27;
  localparam int ERR_W  = 28;
  localparam int INC_W  = 37;
  localparam int PROP_W = 45;
  localparam int MULB_W = 17;
  localparam int PC_W   = 4;

  localparam logic [PC_W-1:0] LOOP_STEP = 4'd2;

  localparam logic [2:0] REG_SPEED_PER_TICK = 3'd0;
  localparam logic [2:0] REG_HALF_TRACK     = 3'd1;
  localparam logic [2:0] REG_INV_RADIUS     = 3'd2;
  localparam logic [2:0] REG_CTRL_PERIOD    = 3'd3;
  localparam logic [2:0] REG_PROP_GAIN      = 3'd4;
  localparam logic [2:0] REG_INTEG_GAIN     = 3'd5;
  localparam logic [2:0] REG_OUTPUT_LIMIT   = 3'd6;

  localparam logic [15:0] RST_SPEED_PER_TICK = 16'd11438;
  localparam logic [15:0] RST_HALF_TRACK     = 16'd7537;
  localparam logic [15:0] RST_INV_RADIUS     = 16'd7273;
  localparam logic [15:0] RST_CTRL_PERIOD    = 16'd6554;
  localparam logic [15:0] RST_PROP_GAIN      = 16'd256;
  localparam logic [15:0] RST_INTEG_GAIN     = 16'd768;
  localparam logic [14:0] RST_OUTPUT_LIMIT   = 15'd32767;

  typedef struct packed {
    logic signed [15:0] left_ticks;
    logic signed [15:0] right_ticks;
    logic signed [15:0] linear_speed;
    logic signed [15:0] turn_rate;
  } item_t;

  typedef struct packed {
    logic signed [15:0] pwm_left;
    logic signed [15:0] pwm_right;
  } result_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [15:0] speed_per_tick;
    logic [15:0] half_track;
    logic [15:0] inverse_wheel_radius;
    logic [15:0] control_period;
    logic [15:0] proportional_gain;
    logic [15:0] integral_gain;
    logic [14:0] output_limit;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_TURN, MUL_MEAS, MUL_TGT, MUL_INC, MUL_PROP, MUL_INTG
  } mul_sel_t;

  typedef enum logic [3:0] {
    ALU_NOP, ALU_TURN, ALU_VEL, ALU_MEAS, ALU_ERR, ALU_INTEG, ALU_ACC_LD,
    ALU_ACC_ADD, ALU_PWM
  } alu_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT, SEQ_LOOP, SEQ_END
  } seq_op_t;

  typedef struct packed {
    mul_sel_t        mul_sel;
    alu_op_t         alu_op;
    seq_op_t         seq_op;
    logic [PC_W-1:0] jmp;
  } uword_t;

  typedef struct packed {
    logic     en;
    logic     emit;
    logic     wheel;
    mul_sel_t mul_sel;
    alu_op_t  alu_op;
  } ctrl_t;

  function automatic uword_t mk_uw(mul_sel_t m, alu_op_t a, seq_op_t s,
                                   logic [PC_W-1:0] j);
    uword_t w;
    w.mul_sel = m;
    w.alu_op  = a;
    w.seq_op  = s;
    w.jmp     = j;
    return w;
  endfunction

  // Each step issues at most one multiply; a product is used by the step after the one that issued it.
  function automatic uword_t ucode(logic [PC_W-1:0] step);
    uword_t w;
    case (step)
      4'd0:    w = mk_uw(MUL_TURN, ALU_NOP,     SEQ_NEXT, '0);
      4'd1:    w = mk_uw(MUL_NONE, ALU_TURN,    SEQ_NEXT, '0);
      4'd2:    w = mk_uw(MUL_MEAS, ALU_VEL,     SEQ_NEXT, '0);
      4'd3:    w = mk_uw(MUL_TGT,  ALU_MEAS,    SEQ_NEXT, '0);
      4'd4:    w = mk_uw(MUL_NONE, ALU_ERR,     SEQ_NEXT, '0);
      4'd5:    w = mk_uw(MUL_INC,  ALU_NOP,     SEQ_NEXT, '0);
      4'd6:    w = mk_uw(MUL_PROP, ALU_INTEG,   SEQ_NEXT, '0);
      4'd7:    w = mk_uw(MUL_INTG, ALU_ACC_LD,  SEQ_NEXT, '0);
      4'd8:    w = mk_uw(MUL_NONE, ALU_ACC_ADD, SEQ_NEXT, '0);
      4'd9:    w = mk_uw(MUL_NONE, ALU_PWM,     SEQ_LOOP, LOOP_STEP);
      default: w = mk_uw(MUL_NONE, ALU_NOP,     SEQ_END,  '0);
    endcase
    return w;
  endfunction

endpackage

### rtl/core/ddpi_chan_if.sv
// Valid/ready channel interface carrying one payload item.
interface ddpi_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

### rtl/core/ddpi_cfg.sv
// Configuration register file of the wheel PI controller.
module ddpi_cfg
  import ddpi_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  input  cfg_wr_t   wr,
  output cfg_regs_t regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.speed_per_tick       <= RST_SPEED_PER_TICK;
      regs.half_track           <= RST_HALF_TRACK;
      regs.inverse_wheel_radius <= RST_INV_RADIUS;
      regs.control_period       <= RST_CTRL_PERIOD;
      regs.proportional_gain    <= RST_PROP_GAIN;
      regs.integral_gain        <= RST_INTEG_GAIN;
      regs.output_limit         <= RST_OUTPUT_LIMIT;
    end else if (wr_valid) begin
      unique case (wr.index)
        REG_SPEED_PER_TICK: regs.speed_per_tick       <= wr.data;
        REG_HALF_TRACK:     regs.half_track           <= wr.data;
        REG_INV_RADIUS:     regs.inverse_wheel_radius <= wr.data;
        REG_CTRL_PERIOD:    regs.control_period       <= wr.data;
        REG_PROP_GAIN:      regs.proportional_gain    <= wr.data;
        REG_INTEG_GAIN:     regs.integral_gain        <= wr.data;
        REG_OUTPUT_LIMIT:   regs.output_limit         <= wr.data[14:0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

endmodule

### rtl/core/ddpi_seq.sv
// Microcode sequencer: step counter, wheel loop, item and result handshakes.
module ddpi_seq
  import ddpi_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  load,
  input  logic  out_ready,
  output logic  out_valid,
  output ctrl_t ctrl
);

  logic            busy;
  logic            wheel;
  logic [PC_W-1:0] pc;
  uword_t          uw;
  logic            last;
  logic            out_free;

  always_comb begin
    uw           = ucode(pc);
    last         = (uw.seq_op == SEQ_END) || ((uw.seq_op == SEQ_LOOP) && wheel);
    out_free     = !out_valid || out_ready;
    in_ready     = !busy;
    load         = in_valid && !busy;
    // hold the final step while the previous result is still waiting
    ctrl.en      = busy && !(last && !out_free);
    ctrl.emit    = busy && last && out_free;
    ctrl.wheel   = wheel;
    ctrl.mul_sel = uw.mul_sel;
    ctrl.alu_op  = uw.alu_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      wheel <= 1'b0;
      pc    <= '0;
    end else if (load) begin
      busy  <= 1'b1;
      wheel <= 1'b0;
      pc    <= '0;
    end else if (ctrl.en) begin
      unique case (uw.seq_op)
        SEQ_NEXT: pc <= pc + 1'b1;
        SEQ_LOOP: begin
          if (!wheel) begin
            pc    <= uw.jmp;
            wheel <= 1'b1;
          end else begin
            busy <= 1'b0;
          end
        end
        SEQ_END:  busy <= 1'b0;
        default:  busy <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### rtl/core/ddpi_dp.sv
// Datapath: one shared multiplier, working registers, integrators and output.
module ddpi_dp
  import ddpi_pkg::*;
#(
  parameter int INTEGRATOR_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  ctrl_t     ctrl,
  input  logic      load,
  input  item_t     item_in,
  input  cfg_regs_t regs,
  output result_t   res
);

  localparam int IW  = INTEGRATOR_WIDTH;
  localparam int AW  = (IW > ERR_W) ? IW : ERR_W;
  localparam int PW  = AW + MULB_W;
  localparam int SW  = ((IW > INC_W) ? IW : INC_W) + 1;
  localparam int AIW = IW + 9;
  localparam int ACW = ((AIW > PROP_W) ? AIW : PROP_W) + 1;
  localparam int QW  = ACW - 16;

  item_t                     item_q;
  logic signed [TURN_W-1:0]  turn;
  logic signed [VEL_W-1:0]   vel;
  logic signed [MEAS_W-1:0]  meas;
  logic signed [ERR_W-1:0]   err;
  logic signed [IW-1:0]      integ_l;
  logic signed [IW-1:0]      integ_r;
  logic signed [PW-1:0]      prod;
  logic signed [ACW-1:0]     acc;
  logic signed [15:0]        pwm_l;

  logic signed [AW-1:0]      mul_a;
  logic signed [MULB_W-1:0]  mul_b;
  logic signed [PW-1:0]      p8;
  logic signed [PW-1:0]      p16;
  logic signed [TGT_W-1:0]   tgt;
  logic signed [INC_W-1:0]   inc;
  logic signed [AIW-1:0]     iterm;
  logic signed [IW-1:0]      integ_cur;
  logic signed [SW-1:0]      isum;
  logic signed [SW-1:0]      sat_hi;
  logic signed [SW-1:0]      sat_lo;
  logic signed [IW-1:0]      integ_new;
  logic signed [ACW-1:0]     rnd;
  logic signed [ACW-1:0]     quo;
  logic signed [QW-1:0]      qn;
  logic signed [QW-1:0]      lim;
  logic signed [QW-1:0]      clamped;
  logic signed [15:0]        pwm;

  always_comb begin
    unique case (ctrl.mul_sel)
      MUL_TURN: begin
        mul_a = AW'(item_q.turn_rate);
        mul_b = {1'b0, regs.half_track};
      end
      MUL_MEAS: begin
        mul_a = ctrl.wheel ? AW'(item_q.right_ticks) : AW'(item_q.left_ticks);
        mul_b = {1'b0, regs.speed_per_tick};
      end
      MUL_TGT: begin
        mul_a = AW'(vel);
        mul_b = {1'b0, regs.inverse_wheel_radius};
      end
      MUL_INC: begin
        mul_a = AW'(err);
        mul_b = {1'b0, regs.control_period};
      end
      MUL_PROP: begin
        mul_a = AW'(err);
        mul_b = {1'b0, regs.proportional_gain};
      end
      MUL_INTG: begin
        mul_a = ctrl.wheel ? AW'(integ_r) : AW'(integ_l);
        mul_b = {1'b0, regs.integral_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    p8        = prod >>> 8;
    p16       = prod >>> 16;
    tgt       = p8[TGT_W-1:0];
    inc       = p8[INC_W-1:0];
    iterm     = p8[AIW-1:0];

    // saturating integrator update
    integ_cur = ctrl.wheel ? integ_r : integ_l;
    isum      = SW'(integ_cur) + SW'(inc);
    sat_hi    = '0;
    sat_hi[IW-2:0] = '1;
    sat_lo    = ~sat_hi;
    if (isum > sat_hi) begin
      integ_new = sat_hi[IW-1:0];
    end else if (isum < sat_lo) begin
      integ_new = sat_lo[IW-1:0];
    end else begin
      integ_new = isum[IW-1:0];
    end

    // truncate toward zero, then clamp to the limit
    rnd     = acc + $signed({{(ACW-16){1'b0}}, {16{acc[ACW-1]}}});
    quo     = rnd >>> 16;
    qn      = quo[QW-1:0];
    lim     = QW'({1'b0, regs.output_limit});
    if (qn > lim) begin
      clamped = lim;
    end else if (qn < -lim) begin
      clamped = -lim;
    end else begin
      clamped = qn;
    end
    pwm     = clamped[15:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_q <= item_in;
    end
    if (ctrl.en) begin
      prod <= mul_a * mul_b;
      unique case (ctrl.alu_op)
        ALU_NOP:     ;
        ALU_TURN:    turn <= p16[TURN_W-1:0];
        ALU_VEL: begin
          if (ctrl.wheel) begin
            vel <= VEL_W'(item_q.linear_speed) + VEL_W'(turn);
          end else begin
            vel <= VEL_W'(item_q.linear_speed) - VEL_W'(turn);
          end
        end
        ALU_MEAS:    meas <= p8[MEAS_W-1:0];
        ALU_ERR:     err <= ERR_W'(tgt) - ERR_W'(meas);
        ALU_INTEG:   ;
        ALU_ACC_LD:  acc <= ACW'($signed(prod[PROP_W-1:0]));
        ALU_ACC_ADD: acc <= acc + ACW'(iterm);
        ALU_PWM: begin
          if (!ctrl.wheel) begin
            pwm_l <= pwm;
          end
          if (ctrl.emit) begin
            res.pwm_left  <= pwm_l;
            res.pwm_right <= pwm;
          end
        end
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_l <= '0;
      integ_r <= '0;
    end else if (ctrl.en && (ctrl.alu_op == ALU_INTEG)) begin
      if (ctrl.wheel) begin
        integ_r <= integ_new;
      end else begin
        integ_l <= integ_new;
      end
    end
  end

endmodule

### rtl/core/diff_drive_wheel_pi_controller.sv
// Differential-drive wheel PI speed controller, top level.
// Each accepted item runs the 18-step microcode program
//   (two shared steps, then eight steps per wheel on one shared multiplier);
// no new item is accepted until its final step has registered the result.
// A waiting result does not block acceptance; only the final step stalls on it.
// Reset loads the register defaults, clears both integrators and idles.
module diff_drive_wheel_pi_controller
  import ddpi_pkg::*;
#(
  parameter int INTEGRATOR_WIDTH = 32
) (
  input logic         clk,
  input logic         rst,
  ddpi_chan_if.sink   item,
  ddpi_chan_if.source result,
  ddpi_chan_if.sink   cfg
);

  cfg_regs_t regs;
  ctrl_t     ctrl;
  logic      load;
  logic      in_ready;
  logic      out_valid;
  result_t   res;

  assign cfg.ready      = 1'b1;
  assign item.ready     = in_ready;
  assign result.valid   = out_valid;
  assign result.payload = res;

  ddpi_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr       (cfg.payload),
    .regs     (regs)
  );

  ddpi_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (in_ready),
    .load      (load),
    .out_ready (result.ready),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  ddpi_dp #(
    .INTEGRATOR_WIDTH (INTEGRATOR_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .load    (load),
    .item_in (item.payload),
    .regs    (regs),
    .res     (res)
  );

endmodule

### rtl/core/ddpi_checker.sv
// Port-level checker of the wheel PI controller and its bind.
`include "diff_drive_wheel_pi_controller_assert.svh"

module ddpi_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] pwm_left,
  input logic [15:0] pwm_right
);

  `DDPI_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "item taken while busy")
  `DDPI_ASSERT_NOW(a_result_from_work, clk, rst, $rose(out_valid), !$past(in_ready), "result without work")
  `DDPI_ASSERT_NOW(a_pwm_in_range, clk, rst, out_valid, (pwm_left != 16'h8000) && (pwm_right != 16'h8000), "pwm beyond limit")
  `DDPI_ASSERT_NEXT(a_result_held, clk, rst, out_valid && !out_ready, out_valid && $stable(pwm_left) && $stable(pwm_right), "stalled result changed")

endmodule

bind diff_drive_wheel_pi_controller ddpi_checker u_ddpi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .pwm_left  (result.payload.pwm_left),
  .pwm_right (result.payload.pwm_right)
);

### tb/tb_diff_drive_wheel_pi_controller.sv
// Self-checking testbench for the differential-drive wheel PI controller.
`timescale 1ns / 100ps

module tb_diff_drive_wheel_pi_controller;
  import ddpi_pkg::*;

  localparam int INTEG_W = 32;
  localparam longint INTEG_MAX = (longint'(1) <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam logic [2:0] REG_UNMAPPED = 3'd7;
  localparam int SETTLE_CYCLES = 24;

  logic clk;
  logic rst;
  bit   steady;

  ddpi_chan_if #(.payload_t(item_t))   item_if ();
  ddpi_chan_if #(.payload_t(result_t)) result_if ();
  ddpi_chan_if #(.payload_t(cfg_wr_t)) cfg_if ();

  diff_drive_wheel_pi_controller #(.INTEGRATOR_WIDTH(INTEG_W)) DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  // Tracks register values and both wheel integrators; holds the pwm pairs still owed.
  class pwm_predictor;
    cfg_regs_t regs;
    longint    left_acc;
    longint    right_acc;
    result_t   pending_pwm[$];
    int        errors;

    function new();
      regs.speed_per_tick       = RST_SPEED_PER_TICK;
      regs.half_track           = RST_HALF_TRACK;
      regs.inverse_wheel_radius = RST_INV_RADIUS;
      regs.control_period       = RST_CTRL_PERIOD;
      regs.proportional_gain    = RST_PROP_GAIN;
      regs.integral_gain        = RST_INTEG_GAIN;
      regs.output_limit         = RST_OUTPUT_LIMIT;
      left_acc  = 0;
      right_acc = 0;
      errors    = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_SPEED_PER_TICK: regs.speed_per_tick       = val;
        REG_HALF_TRACK:     regs.half_track           = val;
        REG_INV_RADIUS:     regs.inverse_wheel_radius = val;
        REG_CTRL_PERIOD:    regs.control_period       = val;
        REG_PROP_GAIN:      regs.proportional_gain    = val;
        REG_INTEG_GAIN:     regs.integral_gain        = val;
        REG_OUTPUT_LIMIT:   regs.output_limit         = val[14:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] wheel_pwm(logic signed [15:0] ticks, longint vel,
                                    inout longint acc);
      longint meas, tgt, err, sum, drive, pwm, lim;
      meas = (longint'($signed(ticks)) * longint'(regs.speed_per_tick)) >>> 8;
      tgt  = (vel * longint'(regs.inverse_wheel_radius)) >>> 8;
      err  = tgt - meas;
      sum  = acc + ((err * longint'(regs.control_period)) >>> 8);
      if (sum > INTEG_MAX) sum = INTEG_MAX;
      if (sum < INTEG_MIN) sum = INTEG_MIN;
      acc   = sum;
      drive = err * longint'(regs.proportional_gain)
            + ((acc * longint'(regs.integral_gain)) >>> 8);
      // Signed division truncates toward zero
      pwm = drive / 65536;
      lim = longint'(regs.output_limit);
      if (pwm > lim)  pwm = lim;
      if (pwm < -lim) pwm = -lim;
      return pwm[15:0];
    endfunction

    function void add_tick(item_t t);
      longint  turn;
      result_t r;
      turn = (longint'($signed(t.turn_rate)) * longint'(regs.half_track)) >>> 16;
      r.pwm_left  = wheel_pwm(t.left_ticks, longint'($signed(t.linear_speed)) - turn,
                              left_acc);
      r.pwm_right = wheel_pwm(t.right_ticks, longint'($signed(t.linear_speed)) + turn,
                              right_acc);
      pending_pwm.push_back(r);
    endfunction

    function void check_pwm(result_t got);
      result_t want;
      if (pending_pwm.size() == 0) begin
        errors++;
        $display("%0t: unexpected result pwm_left=%0d pwm_right=%0d",
                 $time, got.pwm_left, got.pwm_right);
        return;
      end
      want = pending_pwm.pop_front();
      if (got.pwm_left !== want.pwm_left) begin
        errors++;
        $display("%0t: pwm_left mismatch expected %0d actual %0d",
                 $time, want.pwm_left, got.pwm_left);
      end
      if (got.pwm_right !== want.pwm_right) begin
        errors++;
        $display("%0t: pwm_right mismatch expected %0d actual %0d",
                 $time, want.pwm_right, got.pwm_right);
      end
    endfunction
  endclass

  pwm_predictor pred;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drop the run if it hangs
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) pred.check_pwm(result_if.payload);
  end

  // Result side: unless steady, stall a random number of cycles before taking each item
  initial begin
    int stall;
    result_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
    end
  end

  task automatic send_tick(item_t t);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.payload <= t;
    item_if.valid   <= 1'b1;
    do @(posedge clk); while (!item_if.ready);
    pred.add_tick(t);
  endtask

  task automatic send_fields(logic [15:0] lt, logic [15:0] rt, logic [15:0] lin,
                             logic [15:0] tr);
    item_t t;
    t.left_ticks   = lt;
    t.right_ticks  = rt;
    t.linear_speed = lin;
    t.turn_rate    = tr;
    send_tick(t);
  endtask

  // Hold off until every owed result is back and the block has gone quiet
  task automatic settle();
    item_if.valid <= 1'b0;
    while (pred.pending_pwm.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_wr_t w;
    w.index = idx;
    w.data  = val;
    cfg_if.payload <= w;
    cfg_if.valid   <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    pred.set_reg(idx, val);
  endtask

  // Write every register, then a write to an unmapped index that must be dropped
  task automatic program_regs(cfg_regs_t c);
    logic [15:0] junk;
    junk = 16'($urandom_range(0, 65535));
    write_reg(REG_SPEED_PER_TICK, c.speed_per_tick);
    write_reg(REG_HALF_TRACK,     c.half_track);
    write_reg(REG_INV_RADIUS,     c.inverse_wheel_radius);
    write_reg(REG_CTRL_PERIOD,    c.control_period);
    write_reg(REG_PROP_GAIN,      c.proportional_gain);
    write_reg(REG_INTEG_GAIN,     c.integral_gain);
    write_reg(REG_OUTPUT_LIMIT,   {1'($urandom_range(0, 1)), c.output_limit});
    write_reg(REG_UNMAPPED,       junk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic cfg_regs_t rand_regs();
    cfg_regs_t c;
    c.speed_per_tick       = 16'($urandom_range(0, 65535));
    c.half_track           = 16'($urandom_range(0, 65535));
    c.inverse_wheel_radius = 16'($urandom_range(0, 65535));
    c.control_period       = 16'($urandom_range(0, 65535));
    c.proportional_gain    = 16'($urandom_range(0, 65535));
    c.integral_gain        = 16'($urandom_range(0, 65535));
    c.output_limit         = 15'($urandom_range(0, 32767));
    return c;
  endfunction

  function automatic logic [15:0] edge_value();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Mostly plausible drive commands, with raw and extreme values mixed in
  function automatic item_t rand_tick();
    item_t t;
    int    pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      t.left_ticks   = 16'($urandom_range(0, 600) - 300);
      t.right_ticks  = 16'(t.left_ticks + $urandom_range(0, 80) - 40);
      t.linear_speed = 16'($urandom_range(0, 1024) - 512);
      t.turn_rate    = 16'($urandom_range(0, 1024) - 512);
    end else if (pick < 9) begin
      t = {$urandom, $urandom};
    end else begin
      t.left_ticks   = edge_value();
      t.right_ticks  = edge_value();
      t.linear_speed = edge_value();
      t.turn_rate    = edge_value();
    end
    return t;
  endfunction

  task automatic run_random(int count, bit calm);
    steady = calm;
    repeat (count) send_tick(rand_tick());
    steady = 1'b0;
    settle();
  endtask

  initial begin
    cfg_regs_t c;
    pred = new();
    steady = 1'b0;
    item_if.valid   <= 1'b0;
    item_if.payload <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.payload  <= '0;
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults: field extremes and each command term alone
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_fields(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_fields(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_fields(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    send_fields(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_fields(16'h0000, 16'h0000, 16'h0100, 16'h0000);
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0100);
    send_fields(16'h0064, 16'hFF9C, 16'h0000, 16'h0000);
    send_fields(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_random(140, 1'b0);

    // All registers at maximum: drive both integrators into saturation
    c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF};
    program_regs(c);
    repeat (6) send_fields(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    repeat (6) send_fields(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_random(100, 1'b1);

    // Everything zero, including the output limit
    c = '0;
    program_regs(c);
    run_random(60, 1'b0);

    // Zero limit with default gains: outputs pinned while integrators keep moving, then a limit of 1
    c = '{RST_SPEED_PER_TICK, RST_HALF_TRACK, RST_INV_RADIUS, RST_CTRL_PERIOD,
          RST_PROP_GAIN, RST_INTEG_GAIN, 15'd0};
    program_regs(c);
    run_random(60, 1'b1);
    c.output_limit = 15'd1;
    program_regs(c);
    run_random(100, 1'b0);

    repeat (4) begin
      program_regs(rand_regs());
      run_random(90, 1'($urandom_range(0, 1)));
    end

    settle();
    if (pred.errors == 0 && pred.pending_pwm.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/ddpi_pkg.sv
rtl/core/ddpi_chan_if.sv
rtl/core/ddpi_cfg.sv
rtl/core/ddpi_seq.sv
rtl/core/ddpi_dp.sv
rtl/core/diff_drive_wheel_pi_controller.sv
rtl/core/ddpi_checker.sv
tb/tb_diff_drive_wheel_pi_controller.sv
